/* rtl/gta_pkg.sv */
// ----------------------------------------------------------------------------
// gta_pkg: shared types and constants of the gelu tanh activation
// Fixed-point formats, operation codes and the per-item sideband record.
// ----------------------------------------------------------------------------
package gta_pkg;

  localparam int unsigned DATA_W = 16;  // width of every data field
  localparam int unsigned FRAC_W = 10;  // fraction bits of the data fields
  localparam int unsigned TERMS  = 12;  // taylor terms of e^-r after the leading one
  localparam int unsigned Q_BITS = 31;  // quotient bits of the tanh division

  // operation codes, the unused code behaves as plain gelu
  localparam logic [1:0] OP_GELU  = 2'd0;
  localparam logic [1:0] OP_GATE  = 2'd1;
  localparam logic [1:0] OP_SCALE = 2'd2;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [15:0] K0_Q16  = 16'd52290;       // sqrt(2/pi)
  localparam logic [11:0] K1_Q16  = 12'd2930;        // 0.044715
  localparam logic [19:0] U_CLAMP = 20'hA_0000;      // 10.0 in q16
  localparam logic [15:0] X_BIG   = 16'h2000;        // 8.0 in q10

  // floor(2^47 / ln2_q30), gives k with an error of at most one
  localparam logic [17:0] RECIP_LN2 = 18'((64'd1 << 47) / 64'd744261118);

  typedef logic [DATA_W-1:0] word_t;

  // operands split into sign and magnitude, carried along the pipeline
  typedef struct packed {
    logic [1:0] op;
    logic       xneg;
    logic       zneg;
    logic       sneg;
    word_t      xm;
    word_t      zm;
    word_t      sm;
  } side_t;

  typedef struct packed {
    word_t y;
    logic  sat;
  } res_t;

endpackage

/* rtl/gelu_tanh_activation.sv */
// ----------------------------------------------------------------------------
// gelu_tanh_activation: streaming gelu with tanh approximation
// Element-wise gelu(x), gelu(x)*z or gelu(x)*z*scale in signed q5.10.
//
//   channel  dir  transaction payload
//   s_axis   in   tuser: operation, tdata: x_value, gate_value, scale_value
//   m_axis   out  tdata: y_value, tuser: saturated
//
// one transaction enters per cycle unless the skid register is full; stages:
// input register, 7 argument stages, 26 exponential stages
// (two per taylor term), 31 divider stages, 4 product stages, output register
// reset clears only the valid bits; no clearing pass, ready right after reset
// an output stall parks the item that arrives next in the skid register, which
// freezes the whole pipeline until it drains, so nothing is lost or repeated
// ----------------------------------------------------------------------------
module gelu_tanh_activation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // x_value, gate_value, scale_value
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // y_value
  output logic [0:0]  m_axis_tuser    // saturated
);

  // split a two's complement word into its magnitude
  function automatic gta_pkg::word_t mag_of(input gta_pkg::word_t v);
    mag_of = v[gta_pkg::DATA_W-1] ? gta_pkg::word_t'(~v + 1'b1) : v;
  endfunction

  // pipeline advances whenever the skid register is empty
  logic pipe_en;

  logic           in_vld_q;
  gta_pkg::side_t in_side_d, in_side_q;

  logic           arg_vld, exp_vld, div_vld, res_vld;
  gta_pkg::side_t arg_side, exp_side, div_side;
  logic [29:0]    arg_r;
  logic [4:0]     arg_k;
  logic [30:0]    exp_e, div_th;
  gta_pkg::res_t  res;

  // output register and skid register
  logic          out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  gta_pkg::res_t out_d, out_q, skid_d, skid_q;
  logic          take, inc_vld;

  assign pipe_en       = !skid_vld_q;
  assign s_axis_tready = pipe_en;

  // input register: sign and magnitude of every operand
  always_comb begin
    in_side_d.op   = s_axis_tuser;
    in_side_d.xneg = s_axis_tdata[15];
    in_side_d.zneg = s_axis_tdata[31];
    in_side_d.sneg = s_axis_tdata[47];
    in_side_d.xm   = mag_of(s_axis_tdata[15:0]);
    in_side_d.zm   = mag_of(s_axis_tdata[31:16]);
    in_side_d.sm   = mag_of(s_axis_tdata[47:32]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pipe_en) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      in_side_q <= in_side_d;
    end
  end

  // |u|, clamp and split into k*ln2 + r
  gta_arg u_arg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (in_vld_q),
    .side_i (in_side_q),
    .vld_o  (arg_vld),
    .side_o (arg_side),
    .r_o    (arg_r),
    .k_o    (arg_k)
  );

  // e = e^-r >> k
  gta_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (arg_vld),
    .side_i (arg_side),
    .r_i    (arg_r),
    .k_i    (arg_k),
    .vld_o  (exp_vld),
    .side_o (exp_side),
    .e_o    (exp_e)
  );

  // th = (1 - e) / (1 + e)
  gta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (exp_vld),
    .side_i (exp_side),
    .e_i    (exp_e),
    .vld_o  (div_vld),
    .side_o (div_side),
    .th_o   (div_th)
  );

  // gelu, gate, scale and saturation
  gta_out u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .vld_i  (div_vld),
    .side_i (div_side),
    .th_i   (div_th),
    .vld_o  (res_vld),
    .res_o  (res)
  );

  // the last pipeline stage hands its item over only when the pipeline moves
  always_comb begin
    take       = out_vld_q && m_axis_tready;
    inc_vld    = res_vld && pipe_en;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    priority if (skid_vld_q) begin
      // drain the skid register first
      if (!out_vld_q || take) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || take) begin
      out_vld_d = inc_vld;
      out_d     = res;
    end else if (inc_vld) begin
      // output is blocked, park the item in flight
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_q.y;
  assign m_axis_tuser[0] = out_q.sat;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds an item while the output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid register filled without an output stall");

  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
    else $error("saturated result not at a range limit");

endmodule

/* rtl/gta_arg.sv */
// ----------------------------------------------------------------------------
// gta_arg: inner argument and range reduction
// Forms |u| = k0*(|x| + k1*|x|^3), clamps it and splits 2|u| into k*ln2 + r.
// ----------------------------------------------------------------------------
module gta_arg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  gta_pkg::side_t side_i,
  output logic           vld_o,
  output gta_pkg::side_t side_o,
  output logic [29:0]    r_o,
  output logic [4:0]     k_o
);

  localparam int unsigned NST = 7;

  logic [NST-1:0] vld_q;
  gta_pkg::side_t side_q [NST];

  logic [25:0] sq_d, sq_q;
  logic [38:0] cube_d, cube_q;
  logic [50:0] tk, tr;
  logic [14:0] t_d, t_q;
  logic [15:0] s_sum;
  logic [31:0] us;
  logic [21:0] umr_d, umr_q;
  logic        big;
  logic [19:0] um_d, um_q;
  logic [37:0] kp;
  logic [4:0]  kest_d, kest_q, k0_q, k_d, k_q;
  logic [34:0] r0w;
  logic [30:0] r0_d, r0_q;
  logic [29:0] r_d, r_q;

  always_comb begin
    sq_d   = 26'(side_i.xm[12:0]) * 26'(side_i.xm[12:0]);
    cube_d = 39'(sq_q) * 39'(side_q[0].xm[12:0]);
    tk     = 51'(cube_q) * 51'(gta_pkg::K1_Q16);
    tr     = tk + (51'd1 << 35);
    t_d    = tr[50:36];
    s_sum  = 16'(side_q[2].xm[12:0]) + 16'(t_q);
    us     = 32'(s_sum) * 32'(gta_pkg::K0_Q16) + 32'd512;
    umr_d  = us[31:10];
    // large inputs always clamp, the cube path is then ignored
    big    = side_q[3].xm >= gta_pkg::X_BIG;
    um_d   = (big || umr_q > 22'(gta_pkg::U_CLAMP)) ? gta_pkg::U_CLAMP : umr_q[19:0];
    kp     = 38'(um_d) * 38'(gta_pkg::RECIP_LN2);
    kest_d = kp[36:32];
    r0w    = {um_q, 15'd0} - 35'(kest_q) * 35'(gta_pkg::LN2_Q30);
    r0_d   = r0w[30:0];
    // estimate may be one low
    if (r0_q >= 31'(gta_pkg::LN2_Q30)) begin
      r_d = 30'(r0_q - 31'(gta_pkg::LN2_Q30));
      k_d = k0_q + 5'd1;
    end else begin
      r_d = r0_q[29:0];
      k_d = k0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < NST; i++) begin
        side_q[i] <= side_q[i-1];
      end
      sq_q   <= sq_d;
      cube_q <= cube_d;
      t_q    <= t_d;
      umr_q  <= umr_d;
      um_q   <= um_d;
      kest_q <= kest_d;
      r0_q   <= r0_d;
      k0_q   <= kest_q;
      r_q    <= r_d;
      k_q    <= k_d;
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = side_q[NST-1];
  assign r_o    = r_q;
  assign k_o    = k_q;

  a_reduced_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> (r_o < gta_pkg::LN2_Q30 && k_o <= 5'd29))
    else $error("range reduction left r or k out of range");

endmodule

/* rtl/gta_exp.sv */
// ----------------------------------------------------------------------------
// gta_exp: exponential e^-2|u|
// Taylor series of e^-r, one multiply stage and one reciprocal stage per term,
// then the shift by k.
// ----------------------------------------------------------------------------
module gta_exp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  gta_pkg::side_t side_i,
  input  logic [29:0]    r_i,
  input  logic [4:0]     k_i,
  output logic           vld_o,
  output gta_pkg::side_t side_o,
  output logic [30:0]    e_o
);

  localparam int unsigned NST = 2 * gta_pkg::TERMS + 1;

  typedef struct packed {
    gta_pkg::side_t     side;
    logic [29:0]        r;
    logic [4:0]         k;
    logic signed [31:0] sum;
    logic [30:0]        term;
  } exp_t;

  exp_t           src  [NST];
  exp_t           st_d [NST];
  exp_t           st_q [NST];
  logic [NST-1:0] vld_q;

  logic signed [31:0] sum_c;
  logic [30:0]        pos, sh, e_d, e_q;
  logic               e_vld_q;
  gta_pkg::side_t     e_side_q;

  always_comb begin
    src[0].side = side_i;
    src[0].r    = r_i;
    src[0].k    = k_i;
    src[0].sum  = '0;
    src[0].term = gta_pkg::ONE_Q30;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    if (g > 0) begin : g_src
      assign src[g] = st_q[g-1];
    end

    if (g == NST - 1) begin : g_last
      // fold in the last term
      always_comb begin
        st_d[g] = src[g];
        if ((gta_pkg::TERMS % 2) == 0) begin
          st_d[g].sum = $signed(src[g].sum) + $signed(32'(src[g].term));
        end else begin
          st_d[g].sum = $signed(src[g].sum) - $signed(32'(src[g].term));
        end
      end
    end else if ((g % 2) == 0) begin : g_mul
      // term * r, and the previous term joins the sum with alternating sign
      logic [60:0] prod;
      assign prod = 61'(src[g].term) * 61'(src[g].r);
      always_comb begin
        st_d[g]      = src[g];
        st_d[g].term = {1'b0, prod[59:30]};
        if (((g / 2) % 2) == 0) begin
          st_d[g].sum = $signed(src[g].sum) + $signed(32'(src[g].term));
        end else begin
          st_d[g].sum = $signed(src[g].sum) - $signed(32'(src[g].term));
        end
      end
    end else begin : g_rcp
      // exact floor division by the term index through a 2^34 reciprocal
      localparam logic [63:0] DIVISOR = 64'((g + 1) / 2);
      localparam logic [34:0] RECIP   = 35'(((64'd1 << 34) + DIVISOR - 64'd1) / DIVISOR);
      logic [64:0] prod;
      assign prod = 65'(src[g].term[29:0]) * 65'(RECIP);
      always_comb begin
        st_d[g]      = src[g];
        st_d[g].term = {1'b0, prod[63:34]};
      end
    end
  end

  always_comb begin
    sum_c = st_q[NST-1].sum;
    pos   = sum_c[31] ? '0 : sum_c[30:0];
    sh    = pos >> st_q[NST-1].k;
    e_d   = (sh > gta_pkg::ONE_Q30) ? gta_pkg::ONE_Q30 : sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q   <= {vld_q[NST-2:0], vld_i};
      e_vld_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= st_d[i];
      end
      e_q      <= e_d;
      e_side_q <= st_q[NST-1].side;
    end
  end

  assign vld_o  = e_vld_q;
  assign side_o = e_side_q;
  assign e_o    = e_q;

endmodule

/* rtl/gta_div.sv */
// ----------------------------------------------------------------------------
// gta_div: tanh division
// Restoring divider, one quotient bit per stage: th = ((1-e) << 30) / (1+e).
// ----------------------------------------------------------------------------
module gta_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  gta_pkg::side_t side_i,
  input  logic [30:0]    e_i,
  output logic           vld_o,
  output gta_pkg::side_t side_o,
  output logic [30:0]    th_o
);

  localparam int unsigned NST = gta_pkg::Q_BITS;

  typedef struct packed {
    gta_pkg::side_t side;
    logic [31:0]    rem;
    logic [31:0]    den;
    logic [30:0]    quo;
  } div_t;

  div_t           src  [NST];
  div_t           st_d [NST];
  div_t           st_q [NST];
  logic [NST-1:0] vld_q;

  always_comb begin
    src[0].side = side_i;
    src[0].rem  = 32'(gta_pkg::ONE_Q30 - e_i);
    src[0].den  = 32'(gta_pkg::ONE_Q30) + 32'(e_i);
    src[0].quo  = '0;
  end

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic fits;

    if (g > 0) begin : g_src
      // remainder stays below the divisor, so the shift cannot overflow
      always_comb begin
        src[g]     = st_q[g-1];
        src[g].rem = {st_q[g-1].rem[30:0], 1'b0};
      end
    end

    assign fits = src[g].rem >= src[g].den;

    always_comb begin
      st_d[g]     = src[g];
      st_d[g].quo = {src[g].quo[29:0], fits};
      if (fits) begin
        st_d[g].rem = src[g].rem - src[g].den;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NST; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign side_o = st_q[NST-1].side;
  assign th_o   = st_q[NST-1].quo;

  a_tanh_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o |-> th_o <= gta_pkg::ONE_Q30)
    else $error("tanh quotient above one");

endmodule

/* rtl/gta_out.sv */
// ----------------------------------------------------------------------------
// gta_out: gelu product, gate and scale
// Forms |x|*(1 +/- th)/2, the optional gate and scale products, then the
// sign and the saturation of the final value.
// ----------------------------------------------------------------------------
module gta_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  gta_pkg::side_t side_i,
  input  logic [30:0]    th_i,
  output logic           vld_o,
  output gta_pkg::res_t  res_o
);

  localparam logic [31:0] RND32 = 32'd1 << (gta_pkg::FRAC_W - 1);
  localparam logic [36:0] RND37 = 37'd1 << (gta_pkg::FRAC_W - 1);

  logic [3:0]     vld_q;
  gta_pkg::side_t side_q [4];

  logic [31:0] factor;
  logic [46:0] gp_d, gp_q, gr;
  logic [15:0] gm_d, gm_q, gm1_q, gm2_q;
  logic [31:0] pr1;
  logic [20:0] p1_d, p1_q, p1b_q;
  logic [36:0] pr2;
  logic [25:0] p2_d, p2_q;

  logic [25:0] mag, cap, magc;
  logic        neg, chk, clip, neg_f;

  always_comb begin
    factor = side_i.xneg ? 32'(gta_pkg::ONE_Q30) - 32'(th_i)
                         : 32'(gta_pkg::ONE_Q30) + 32'(th_i);
    gp_d   = 47'(side_i.xm) * 47'(factor);
    gr     = gp_q + (47'd1 << 30);
    gm_d   = gr[46:31];
    pr1    = 32'(gm_q) * 32'(side_q[1].zm) + RND32;
    p1_d   = pr1[gta_pkg::FRAC_W +: 21];
    pr2    = 37'(p1_q) * 37'(side_q[2].sm) + RND37;
    p2_d   = pr2[gta_pkg::FRAC_W +: 26];
  end

  // final selection, sign and saturation
  always_comb begin
    unique case (side_q[3].op)
      gta_pkg::OP_GATE: begin
        mag = 26'(p1b_q);
        neg = side_q[3].xneg ^ side_q[3].zneg;
        chk = 1'b1;
      end
      gta_pkg::OP_SCALE: begin
        mag = p2_q;
        neg = side_q[3].xneg ^ side_q[3].zneg ^ side_q[3].sneg;
        chk = 1'b1;
      end
      default: begin
        mag = 26'(gm2_q);
        neg = side_q[3].xneg;
        chk = 1'b0;
      end
    endcase
    cap       = neg ? 26'd32768 : 26'd32767;
    clip      = chk && (mag > cap);
    magc      = clip ? cap : mag;
    neg_f     = neg && (magc != '0);
    res_o.y   = neg_f ? 16'(~magc[15:0] + 16'd1) : magc[15:0];
    res_o.sat = clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < 4; i++) begin
        side_q[i] <= side_q[i-1];
      end
      gp_q  <= gp_d;
      gm_q  <= gm_d;
      p1_q  <= p1_d;
      gm1_q <= gm_q;
      p2_q  <= p2_d;
      p1b_q <= p1_q;
      gm2_q <= gm1_q;
    end
  end

  assign vld_o = vld_q[3];

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the gelu tanh activation stream
// Drives x, gate and scale operands under random input gaps and output
// stalls, predicts each gelu result in fixed point, and compares every output
// transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  // the spare operation code falls back to plain gelu
  localparam logic [1:0] OP_SPARE = 2'd3;

  // predictor constants, q16 / q30 as in the fixed-point description
  localparam longint unsigned ONE_30   = 64'd1 << 30;
  localparam longint unsigned C_K0     = 64'd52290;
  localparam longint unsigned C_K1     = 64'd2930;
  localparam longint unsigned C_LN2    = 64'd744261118;
  localparam longint unsigned C_UCLAMP = 64'd10 << 16;
  localparam longint unsigned C_XBIG   = 64'd8 << 10;
  localparam longint unsigned WIDE_LIM = 64'd1 << 62;
  localparam int unsigned     DRAIN_CYCLES = 80;  // a bit over the pipeline depth

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // x_value, gate_value, scale_value
  logic [1:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // y_value
  logic [0:0]  m_axis_tuser;   // saturated

  gta_pkg::res_t expected_y_q[$];
  int            n_errors;
  bit            idle_on;

  gelu_tanh_activation DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------

  // two's complement word to magnitude, sign returned apart
  function automatic longint unsigned word_mag(gta_pkg::word_t w, output logic neg);
    neg = w[gta_pkg::DATA_W-1];
    return neg ? (64'd65536 - {48'd0, w}) : {48'd0, w};
  endfunction

  // round(a*b / 2^10) to nearest, ties away, clipped to lim
  function automatic longint unsigned mul_q10(longint unsigned a, longint unsigned b,
                                              longint unsigned lim, inout logic clip);
    longint unsigned r;
    r = (a * b + 64'd512) >> 10;
    if (r > lim) begin
      clip = 1'b1;
      return lim;
    end
    return r;
  endfunction

  function automatic gta_pkg::res_t gelu_predict(logic [1:0] op, gta_pkg::word_t x,
                                                 gta_pkg::word_t z, gta_pkg::word_t s);
    logic            xneg, zneg, sneg, neg, clip, wide_clip;
    longint unsigned xm, zm, sm, um, cube, inner, a, k, r, term, e, th, factor;
    longint unsigned gm, mag, lim, p;
    longint          series;
    gta_pkg::res_t   res;
    xm = word_mag(x, xneg);
    zm = word_mag(z, zneg);
    sm = word_mag(s, sneg);
    clip = 1'b0;
    wide_clip = 1'b0;
    // inner argument |u| in q16, clamped to 10.0; large |x| always clamps
    if (xm >= C_XBIG) begin
      um = C_UCLAMP;
    end else begin
      cube  = xm * xm * xm;
      inner = xm + ((cube * C_K1 + (64'd1 << 35)) >> 36);
      um    = (inner * C_K0 + 64'd512) >> 10;
      if (um > C_UCLAMP) um = C_UCLAMP;
    end
    // e^-2|u| by range reduction k*ln2 + r and a 13-term series of e^-r
    a = um << 15;
    k = a / C_LN2;
    r = a - k * C_LN2;
    term   = ONE_30;
    series = longint'(ONE_30);
    for (int i = 1; i <= gta_pkg::TERMS; i++) begin
      term = ((term * r) >> 30) / longint'(i);
      if (i % 2 == 1) series = series - longint'(term);
      else            series = series + longint'(term);
    end
    if (series < 0) series = 0;
    e = (k > 62) ? 64'd0 : (longint'(series) >> k);
    if (e > ONE_30) e = ONE_30;
    th = ((ONE_30 - e) << 30) / (ONE_30 + e);
    // gelu magnitude, sign follows x
    factor = xneg ? (ONE_30 - th) : (ONE_30 + th);
    gm = (xm * factor + (64'd1 << 30)) >> 31;
    if (op == gta_pkg::OP_GATE || op == gta_pkg::OP_SCALE) begin
      neg = xneg ^ zneg;
      if (op == gta_pkg::OP_SCALE) neg = neg ^ sneg;
      lim = neg ? 64'd32768 : 64'd32767;
      if (op == gta_pkg::OP_GATE) begin
        mag = mul_q10(gm, zm, lim, clip);
      end else begin
        // gelu*z kept wide, only the final product saturates
        p   = mul_q10(gm, zm, WIDE_LIM, wide_clip);
        mag = mul_q10(p, sm, lim, clip);
      end
    end else begin
      neg = xneg;
      mag = gm;
    end
    if (mag == 0) neg = 1'b0;  // zero is always +0
    res.y   = neg ? gta_pkg::word_t'(64'd65536 - mag) : gta_pkg::word_t'(mag);
    res.sat = clip;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    n_errors++;
  endtask

  // every output transaction is matched against the oldest prediction
  always @(posedge clk_i) begin : check_output
    gta_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_y_q.size() == 0) begin
        report_mismatch("unexpected output transaction", m_axis_tdata, 16'h0);
      end else begin
        want = expected_y_q.pop_front();
        if (m_axis_tdata !== want.y)
          report_mismatch("y_value", m_axis_tdata, want.y);
        if (m_axis_tuser[0] !== want.sat)
          report_mismatch("saturated", {15'd0, m_axis_tuser[0]}, {15'd0, want.sat});
      end
    end
  end

  // output stalls in bursts of random length while idling is enabled
  initial begin : ready_gen
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // one input transaction; called and returning at a falling edge
  task automatic send_item(logic [1:0] op, gta_pkg::word_t x, gta_pkg::word_t z,
                           gta_pkg::word_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {s, z, x};
    s_axis_tuser  = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_y_q.push_back(gelu_predict(op, x, z, s));
    @(negedge clk_i);
  endtask

  // random operands; narrow keeps |x| within 8.0 and the gate and scale
  // within 2.0, so few products saturate
  task automatic send_random_item(bit narrow);
    logic [1:0]     op;
    gta_pkg::word_t x, z, s;
    op = 2'($urandom_range(0, 3));
    x  = gta_pkg::word_t'($urandom);
    z  = gta_pkg::word_t'($urandom);
    s  = gta_pkg::word_t'($urandom);
    if (narrow || $urandom_range(0, 1) == 0) begin
      x = gta_pkg::word_t'($urandom_range(0, 16383) - 8192);
      z = gta_pkg::word_t'($urandom_range(0, 4095) - 2048);
      s = gta_pkg::word_t'($urandom_range(0, 4095) - 2048);
    end
    send_item(op, x, z, s);
  endtask

  // sender holds off until the whole pipeline has drained
  task automatic wait_drained();
    while (expected_y_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    // plain gelu across the x range, both sides of the clamp threshold
    send_item(gta_pkg::OP_GELU, 16'h0000, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h0001, 16'hFFFF, 16'hFFFF);  // unused fields ignored
    send_item(gta_pkg::OP_GELU, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h0400, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'hFC00, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h1FFF, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h2000, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'hE000, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'hDFFF, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GELU, 16'h8000, 16'h0000, 16'h0000);
    // spare code acts as plain gelu
    send_item(OP_SPARE, 16'h0C00, 16'h1234, 16'h8000);
    // gated, including both saturation limits and a zero product
    send_item(gta_pkg::OP_GATE, 16'h0400, 16'h0400, 16'h7FFF);
    send_item(gta_pkg::OP_GATE, 16'h7FFF, 16'h7FFF, 16'h0000);
    send_item(gta_pkg::OP_GATE, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(gta_pkg::OP_GATE, 16'hF400, 16'h0000, 16'h0000);
    send_item(gta_pkg::OP_GATE, 16'h8000, 16'h7FFF, 16'h0000);
    send_item(gta_pkg::OP_GATE, 16'h0020, 16'h8000, 16'hFFFF);
    // gate and scale
    send_item(gta_pkg::OP_SCALE, 16'h0800, 16'h0400, 16'h0400);
    send_item(gta_pkg::OP_SCALE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(gta_pkg::OP_SCALE, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_item(gta_pkg::OP_SCALE, 16'h0400, 16'h8000, 16'h8000);
    send_item(gta_pkg::OP_SCALE, 16'h7FFF, 16'h0001, 16'h0000);
    send_item(gta_pkg::OP_SCALE, 16'hFE00, 16'hFC00, 16'h0200);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic test_random_mixed(int n);
    repeat (n) send_random_item(1'b0);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic test_random_narrow(int n);
    repeat (n) send_random_item(1'b1);
    s_axis_tvalid = 1'b0;
  endtask

  // full rate stream, no gaps and no stalls
  task automatic test_back_to_back(int n);
    idle_on = 1'b0;
    repeat (n) send_random_item($urandom_range(0, 1));
    s_axis_tvalid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    n_errors      = 0;
    idle_on       = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = gta_pkg::OP_GELU;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    wait_drained();
    test_random_mixed(700);
    test_random_narrow(400);
    wait_drained();
    test_back_to_back(400);

    while (expected_y_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
